### rtl/core/cpu_alu_with_flags_assert.svh
// assertion macros for the cpu alu block
// no dependencies; included by the modules that check their own logic
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

`ifndef SYNTH
`define CALU_ASSERT_NOW(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("calu check failed");
`define CALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calu check failed");
`else
`define CALU_ASSERT_NOW(label, clk, rst_n, expr)
`define CALU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/calu_pkg.sv
// shared types and operation codes for the cpu alu block
// no dependencies
package calu_pkg;

  localparam int unsigned CmdW  = 5;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 5'd0,
    CMD_ADC    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_SBC    = 5'd3,
    CMD_AND    = 5'd4,
    CMD_OR     = 5'd5,
    CMD_XOR    = 5'd6,
    CMD_CP     = 5'd7,
    CMD_INC    = 5'd8,
    CMD_DEC    = 5'd9,
    CMD_CPL    = 5'd10,
    CMD_CCF    = 5'd11,
    CMD_SCF    = 5'd12,
    CMD_ADD16  = 5'd13,
    CMD_ADDSP  = 5'd14,
    CMD_INC16  = 5'd15,
    CMD_DEC16  = 5'd16,
    CMD_LOAD_A = 5'd17
  } cmd_e;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_res;
    logic [WordW-1:0] word_res;
    logic [ByteW-1:0] acc;
    flags_t           flags;
  } exec_res_t;

endpackage

### rtl/core/calu_exec.sv
// combinational execute logic: one operation against accumulator and flags
// depends on calu_pkg
module calu_exec import calu_pkg::*; (
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [ByteW-1:0] operand_i,
  input  logic [WordW-1:0] base_word_i,
  input  logic [WordW-1:0] addend_word_i,
  input  logic [ByteW-1:0] acc_i,
  input  flags_t           flags_i,
  output exec_res_t        res_o
);

  logic             cin;
  logic             use_cin;
  logic [ByteW:0]   add_sum;
  logic [4:0]       add_half;
  logic [ByteW:0]   sub_diff;
  logic [4:0]       sub_half;
  logic [WordW:0]   w_sum;
  logic [12:0]      w_half;
  logic [WordW-1:0] sp_sum;
  logic [ByteW:0]   sp_low;
  logic [4:0]       sp_half;
  logic [ByteW-1:0] inc_val;
  logic [ByteW-1:0] dec_val;

  assign use_cin  = (cmd_i == CMD_ADC) || (cmd_i == CMD_SBC);
  assign cin      = flags_i.c & use_cin;
  assign add_sum  = {1'b0, acc_i} + {1'b0, operand_i} + {8'd0, cin};
  assign add_half = {1'b0, acc_i[3:0]} + {1'b0, operand_i[3:0]} + {4'd0, cin};
  assign sub_diff = {1'b0, acc_i} - {1'b0, operand_i} - {8'd0, cin};
  assign sub_half = {1'b0, acc_i[3:0]} - {1'b0, operand_i[3:0]} - {4'd0, cin};
  assign w_sum    = {1'b0, base_word_i} + {1'b0, addend_word_i};
  assign w_half   = {1'b0, base_word_i[11:0]} + {1'b0, addend_word_i[11:0]};
  assign sp_sum   = base_word_i + {{8{operand_i[7]}}, operand_i};
  assign sp_low   = {1'b0, base_word_i[7:0]} + {1'b0, operand_i};
  assign sp_half  = {1'b0, base_word_i[3:0]} + {1'b0, operand_i[3:0]};
  assign inc_val  = operand_i + 8'd1;
  assign dec_val  = operand_i - 8'd1;

  always_comb begin
    res_o.byte_res = '0;
    res_o.word_res = '0;
    res_o.acc      = acc_i;
    res_o.flags    = flags_i;
    unique case (cmd_i)
      CMD_ADD, CMD_ADC: begin
        res_o.byte_res = add_sum[ByteW-1:0];
        res_o.acc      = add_sum[ByteW-1:0];
        res_o.flags    = '{z: (add_sum[ByteW-1:0] == '0), n: 1'b0,
                           h: add_half[4], c: add_sum[ByteW]};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        res_o.byte_res = sub_diff[ByteW-1:0];
        if (cmd_i != CMD_CP) begin
          res_o.acc = sub_diff[ByteW-1:0];
        end
        res_o.flags    = '{z: (sub_diff[ByteW-1:0] == '0), n: 1'b1,
                           h: sub_half[4], c: sub_diff[ByteW]};
      end
      CMD_AND: begin
        res_o.byte_res = acc_i & operand_i;
        res_o.acc      = acc_i & operand_i;
        res_o.flags    = '{z: ((acc_i & operand_i) == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_OR: begin
        res_o.byte_res = acc_i | operand_i;
        res_o.acc      = acc_i | operand_i;
        res_o.flags    = '{z: ((acc_i | operand_i) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_XOR: begin
        res_o.byte_res = acc_i ^ operand_i;
        res_o.acc      = acc_i ^ operand_i;
        res_o.flags    = '{z: ((acc_i ^ operand_i) == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_INC: begin
        res_o.byte_res = inc_val;
        res_o.flags    = '{z: (inc_val == '0), n: 1'b0,
                           h: (operand_i[3:0] == 4'hF), c: flags_i.c};
      end
      CMD_DEC: begin
        res_o.byte_res = dec_val;
        res_o.flags    = '{z: (dec_val == '0), n: 1'b1,
                           h: (operand_i[3:0] == 4'h0), c: flags_i.c};
      end
      CMD_CPL: begin
        res_o.byte_res = ~acc_i;
        res_o.acc      = ~acc_i;
        res_o.flags    = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      CMD_CCF: begin
        res_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      CMD_SCF: begin
        res_o.flags = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      CMD_ADD16: begin
        res_o.word_res = w_sum[WordW-1:0];
        res_o.flags    = '{z: flags_i.z, n: 1'b0, h: w_half[12], c: w_sum[WordW]};
      end
      CMD_ADDSP: begin
        res_o.word_res = sp_sum;
        res_o.flags    = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[ByteW]};
      end
      CMD_INC16: begin
        res_o.word_res = base_word_i + 16'd1;
      end
      CMD_DEC16: begin
        res_o.word_res = base_word_i - 16'd1;
      end
      CMD_LOAD_A: begin
        res_o.byte_res = operand_i;
        res_o.acc      = operand_i;
      end
      default: begin
        res_o.byte_res = '0;
      end
    endcase
  end

endmodule

### rtl/core/cpu_alu_with_flags.sv
// 8-bit cpu alu with accumulator and z/n/h/c flags
// depends on calu_pkg, calu_exec and cpu_alu_with_flags_assert.svh
//
// usage: one input channel (in_valid_i / in_stall_o) carries a command code,
// an 8-bit operand and two 16-bit words; one output channel
// (out_valid_o / out_stall_i) returns the byte result, word result and the
// accumulator and flags after the operation. a beat moves when valid is high
// and stall is low.
// an accepted beat goes through the input register, then execute logic into
// the result register. throughput: one beat per cycle while out_stall_i is low;
// the accumulator and flag feedback closes inside the execute stage.
// reset: accumulator and flags clear to zero, both stages empty.
// when the receiver stalls, the result register holds; one more beat waits
// in the input register, after which in_stall_o rises until the output drains.
module cpu_alu_with_flags import calu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [ByteW-1:0] operand_i,
  input  logic [WordW-1:0] base_word_i,
  input  logic [WordW-1:0] addend_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] byte_result_o,
  output logic [WordW-1:0] word_result_o,
  output logic [ByteW-1:0] accumulator_o,
  output logic [3:0]       flag_bits_o
);

  `include "cpu_alu_with_flags_assert.svh"

  logic             in_valid_q;
  logic [CmdW-1:0]  cmd_q;
  logic [ByteW-1:0] operand_q;
  logic [WordW-1:0] base_q;
  logic [WordW-1:0] addend_q;
  logic             out_valid_q;
  exec_res_t        out_q;
  logic [ByteW-1:0] acc_q;
  flags_t           flags_q;
  exec_res_t        exec_res;
  logic             out_free;
  logic             fire;
  logic             in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  calu_exec u_exec (
    .cmd_i         (cmd_q),
    .operand_i     (operand_q),
    .base_word_i   (base_q),
    .addend_word_i (addend_q),
    .acc_i         (acc_q),
    .flags_i       (flags_q),
    .res_o         (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        acc_q   <= exec_res.acc;
        flags_q <= exec_res.flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q     <= cmd_i;
      operand_q <= operand_i;
      base_q    <= base_word_i;
      addend_q  <= addend_word_i;
    end
    if (fire) begin
      out_q <= exec_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_result_o = out_q.byte_res;
  assign word_result_o = out_q.word_res;
  assign accumulator_o = out_q.acc;
  assign flag_bits_o   = out_q.flags;

  `CALU_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !fire, $stable(acc_q) && $stable(flags_q))
  `CALU_ASSERT_NOW(a_out_matches_state, clk_i, rst_ni,
    !out_valid_q || ((out_q.acc == acc_q) && (out_q.flags == flags_q)))
  `CALU_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, fire, out_valid_q)
  `CALU_ASSERT_NEXT(a_stage_kept, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q)

endmodule

### test/tb_cpu_alu_with_flags.sv
`timescale 1ns / 100ps
// self-checking testbench for the cpu_alu_with_flags accumulator/flag alu
// depends on calu_pkg and cpu_alu_with_flags; predicts every result beat in-line
module tb_cpu_alu_with_flags import calu_pkg::*; ();

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 300000;
  localparam logic [CmdW-1:0] CmdUndefLo = CmdW'(CMD_LOAD_A + 1);
  localparam logic [CmdW-1:0] CmdUndefHi = '1;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [CmdW-1:0]  cmd_i         = '0;
  logic [ByteW-1:0] operand_i     = '0;
  logic [WordW-1:0] base_word_i   = '0;
  logic [WordW-1:0] addend_word_i = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [ByteW-1:0] byte_result_o;
  logic [WordW-1:0] word_result_o;
  logic [ByteW-1:0] accumulator_o;
  logic [3:0]       flag_bits_o;

  logic [ByteW-1:0] model_acc   = '0;
  flags_t           model_flags = '0;
  exec_res_t        alu_result_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned ops_sent     = 0;
  int unsigned undef_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold      = 0;
  int unsigned rx_run       = 0;

  cpu_alu_with_flags u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .operand_i     (operand_i),
    .base_word_i   (base_word_i),
    .addend_word_i (addend_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_result_o (byte_result_o),
    .word_result_o (word_result_o),
    .accumulator_o (accumulator_o),
    .flag_bits_o   (flag_bits_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("cpu_alu_with_flags verification failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic exec_res_t alu_model_step(input logic [CmdW-1:0] cmd,
                                               input logic [ByteW-1:0] op,
                                               input logic [WordW-1:0] base,
                                               input logic [WordW-1:0] addend);
    exec_res_t  res;
    logic       cy;
    logic [8:0] sum9;
    logic [4:0] nib;
    logic [16:0] sum17;
    logic [12:0] sum13;
    res = '0;
    cy  = 1'b0;
    case (cmd)
      CMD_ADD, CMD_ADC: begin
        if (cmd == CMD_ADC) cy = model_flags.c;
        sum9 = {1'b0, model_acc} + {1'b0, op} + {8'd0, cy};
        nib  = {1'b0, model_acc[3:0]} + {1'b0, op[3:0]} + {4'd0, cy};
        res.byte_res = sum9[7:0];
        model_flags  = '{z: sum9[7:0] == 0, n: 1'b0, h: nib[4], c: sum9[8]};
        model_acc    = sum9[7:0];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (cmd == CMD_SBC) cy = model_flags.c;
        sum9 = {1'b0, model_acc} - {1'b0, op} - {8'd0, cy};
        nib  = {1'b0, model_acc[3:0]} - {1'b0, op[3:0]} - {4'd0, cy};
        res.byte_res = sum9[7:0];
        model_flags  = '{z: sum9[7:0] == 0, n: 1'b1, h: nib[4], c: sum9[8]};
        if (cmd != CMD_CP) model_acc = sum9[7:0];
      end
      CMD_AND: begin
        model_acc    = model_acc & op;
        res.byte_res = model_acc;
        model_flags  = '{z: model_acc == 0, n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_OR: begin
        model_acc    = model_acc | op;
        res.byte_res = model_acc;
        model_flags  = '{z: model_acc == 0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_XOR: begin
        model_acc    = model_acc ^ op;
        res.byte_res = model_acc;
        model_flags  = '{z: model_acc == 0, n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_INC: begin
        res.byte_res  = op + 8'd1;
        model_flags.z = res.byte_res == 0;
        model_flags.n = 1'b0;
        model_flags.h = op[3:0] == 4'hF;
      end
      CMD_DEC: begin
        res.byte_res  = op - 8'd1;
        model_flags.z = res.byte_res == 0;
        model_flags.n = 1'b1;
        model_flags.h = op[3:0] == 4'h0;
      end
      CMD_CPL: begin
        model_acc     = ~model_acc;
        res.byte_res  = model_acc;
        model_flags.n = 1'b1;
        model_flags.h = 1'b1;
      end
      CMD_CCF: begin
        model_flags.n = 1'b0;
        model_flags.h = 1'b0;
        model_flags.c = ~model_flags.c;
      end
      CMD_SCF: begin
        model_flags.n = 1'b0;
        model_flags.h = 1'b0;
        model_flags.c = 1'b1;
      end
      CMD_ADD16: begin
        sum17 = {1'b0, base} + {1'b0, addend};
        sum13 = {1'b0, base[11:0]} + {1'b0, addend[11:0]};
        res.word_res  = sum17[15:0];
        model_flags.n = 1'b0;
        model_flags.h = sum13[12];
        model_flags.c = sum17[16];
      end
      CMD_ADDSP: begin
        sum9 = {1'b0, base[7:0]} + {1'b0, op};
        nib  = {1'b0, base[3:0]} + {1'b0, op[3:0]};
        res.word_res = base + {{8{op[7]}}, op};
        model_flags  = '{z: 1'b0, n: 1'b0, h: nib[4], c: sum9[8]};
      end
      CMD_INC16: res.word_res = base + 16'd1;
      CMD_DEC16: res.word_res = base - 16'd1;
      CMD_LOAD_A: begin
        model_acc    = op;
        res.byte_res = op;
      end
      default: ;
    endcase
    res.acc   = model_acc;
    res.flags = model_flags;
    return res;
  endfunction

  task automatic log_mismatch(input string what, input int unsigned got,
                              input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    exec_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (alu_result_q.size() == 0) begin
        log_mismatch("result beat with nothing pending", 0, 0);
      end else begin
        want = alu_result_q.pop_front();
        if (byte_result_o !== want.byte_res)
          log_mismatch("byte_result", byte_result_o, want.byte_res);
        if (word_result_o !== want.word_res)
          log_mismatch("word_result", word_result_o, want.word_res);
        if (accumulator_o !== want.acc)
          log_mismatch("accumulator", accumulator_o, want.acc);
        if (flag_bits_o !== want.flags)
          log_mismatch("flag_bits", flag_bits_o, want.flags);
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else if (rx_run > 0) begin
      out_stall_i <= 1'b1;
      rx_run--;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_stall_i <= 1'b1;
      rx_run = gap_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] op,
                         input logic [WordW-1:0] base, input logic [WordW-1:0] addend);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      repeat (gap_len()) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    operand_i     <= op;
    base_word_i   <= base;
    addend_word_i <= addend;
    do @(posedge clk_i); while (in_stall_o);
    alu_result_q.push_back(alu_model_step(cmd, op, base, addend));
    ops_sent++;
    if (cmd > CMD_LOAD_A) undef_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (alu_result_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'h80;
      4: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      3: return {8'($urandom_range(0, 255)), 8'hFF};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_op();
    logic [CmdW-1:0] cmd;
    if ($urandom_range(0, 99) < 6) cmd = CmdW'($urandom_range(CmdUndefHi, CmdUndefLo));
    else cmd = CmdW'($urandom_range(CMD_LOAD_A, CMD_ADD));
    send_op(cmd, pick_byte(), pick_word(), pick_word());
  endtask

  task automatic test_directed();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_op(CMD_LOAD_A, 8'hFF, '0, '0);
    send_op(CMD_ADD,    8'h01, '0, '0);
    send_op(CMD_ADC,    8'h00, '0, '0);
    send_op(CMD_ADD,    8'h0F, '0, '0);
    send_op(CMD_SUB,    8'h10, '0, '0);
    send_op(CMD_SUB,    8'h01, '0, '0);
    send_op(CMD_SBC,    8'h00, '0, '0);
    send_op(CMD_CP,     8'hFE, '0, '0);
    send_op(CMD_CP,     8'hFF, '0, '0);
    send_op(CMD_AND,    8'h00, '0, '0);
    send_op(CMD_LOAD_A, 8'h5A, '0, '0);
    send_op(CMD_OR,     8'hA5, '0, '0);
    send_op(CMD_XOR,    8'hFF, '0, '0);
    send_op(CMD_INC,    8'hFF, '0, '0);
    send_op(CMD_INC,    8'h0F, '0, '0);
    send_op(CMD_DEC,    8'h00, '0, '0);
    send_op(CMD_DEC,    8'h01, '0, '0);
    send_op(CMD_CPL,    8'h00, '0, '0);
    send_op(CMD_SCF,    8'h00, '0, '0);
    send_op(CMD_CCF,    8'h00, '0, '0);
    send_op(CMD_ADD16,  8'h00, 16'hFFFF, 16'h0001);
    send_op(CMD_ADD16,  8'h00, 16'h0FFF, 16'h0001);
    send_op(CMD_ADDSP,  8'h01, 16'h00FF, '0);
    send_op(CMD_ADDSP,  8'h80, 16'h0000, '0);
    send_op(CMD_INC16,  8'h00, 16'hFFFF, '0);
    send_op(CMD_DEC16,  8'h00, 16'h0000, '0);
    send_op(CmdUndefHi, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_op(CmdUndefLo, 8'h00, '0, '0);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int unsigned n_ops, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n_ops) send_random_op();
  endtask

  task automatic test_output_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (2) begin
      rx_hold = 60;
      repeat (30) send_random_op();
      wait_drain();
    end
  endtask

  task automatic test_drain_pauses();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    repeat (6) begin
      repeat ($urandom_range(5, 15)) send_random_op();
      wait_drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_traffic(200, 30, 30);
    test_random_traffic(150, 0, 0);
    test_output_backpressure();
    test_random_traffic(200, 10, 50);
    test_drain_pauses();
    wait_drain();
    repeat (6) @(posedge clk_i);
    $display("sent %0d alu ops (%0d undefined codes): directed corners, random mixes,",
             ops_sent, undef_sent);
    $display("back-to-back streams, long output stalls and drain pauses; %0d beats checked",
             results_seen);
    if (mismatch_cnt == 0 && alu_result_q.size() == 0) begin
      $display("cpu_alu_with_flags verification clean");
    end else begin
      $display("cpu_alu_with_flags verification failed");
    end
    $finish;
  end

endmodule
